// File: rtl/sfr_pkg.sv
// Package for the spherical frame rotation block: CORDIC constants,
// the arctangent table and the pipeline word types. No dependencies.
`default_nettype none
package sfr_pkg;
   localparam int CORDIC_STEPS = 30;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   function automatic logic signed [33:0] atan_step(input logic [4:0] i);
      logic signed [33:0] r;
      case (i)
         5'd0: r = 34'sd536870912;  5'd1: r = 34'sd316933406;
         5'd2: r = 34'sd167458907;  5'd3: r = 34'sd85004756;
         5'd4: r = 34'sd42667331;   5'd5: r = 34'sd21354465;
         5'd6: r = 34'sd10679838;   5'd7: r = 34'sd5340245;
         5'd8: r = 34'sd2670163;    5'd9: r = 34'sd1335087;
         5'd10: r = 34'sd667544;    5'd11: r = 34'sd333772;
         5'd12: r = 34'sd166886;    5'd13: r = 34'sd83443;
         5'd14: r = 34'sd41722;     5'd15: r = 34'sd20861;
         5'd16: r = 34'sd10430;     5'd17: r = 34'sd5215;
         5'd18: r = 34'sd2608;      5'd19: r = 34'sd1304;
         5'd20: r = 34'sd652;       5'd21: r = 34'sd326;
         5'd22: r = 34'sd163;       5'd23: r = 34'sd81;
         5'd24: r = 34'sd41;        5'd25: r = 34'sd20;
         5'd26: r = 34'sd10;        5'd27: r = 34'sd5;
         5'd28: r = 34'sd3;         5'd29: r = 34'sd1;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

   // One CORDIC rotation in flight: vector, residual angle and quadrant.
   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic [1:0]         q;
   } rot_type;

   // Item fields that ride alongside the trig pipeline.
   typedef struct packed {
      logic               opcode;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
   } side_type;
endpackage
`default_nettype wire

// File: rtl/spherical_frame_rotation_top.sv
// Top level of the spherical frame rotation block. Instantiates a chain of
// sfr_cordic_cell stages and the matrix back end. Depends on sfr_pkg.
//
// Usage: present a word on req_* with req_valid; it is taken on a clock
// edge where req_stall is low. Each word yields exactly one rsp_* word.
// The path from acceptance to rsp_valid is 30 CORDIC cells, 5 back-end
// stages and the output register. Throughput is one word per cycle while
// not stalled, set by the CORDIC cell chain, one micro-rotation per cell.
// The whole pipeline advances as one; when rsp_stall holds a finished word
// in the output register, the pipeline freezes and req_stall is raised
// only while the output is full and stalled. Reset clears all valid bits;
// payload registers are not reset. No configuration or clearing pass.
`default_nettype none
module spherical_frame_rotation_top #(
   parameter int ANGLE_BITS = 16,
   parameter int TRIG_FRAC_BITS = 15
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire         req_opcode,
   input  wire  [31:0] req_vec_x,
   input  wire  [31:0] req_vec_y,
   input  wire  [31:0] req_vec_z,
   input  wire  [15:0] req_polar_angle,
   input  wire  [15:0] req_azimuth_angle,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [31:0] rsp_rot_x,
   output logic [31:0] rsp_rot_y,
   output logic [31:0] rsp_rot_z,
   output logic        rsp_saturated
);
   localparam int N = sfr_pkg::CORDIC_STEPS;
   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int RS = 30 - TRIG_FRAC_BITS;
   localparam int PW = 2 * TW;
   localparam int SW = 32 + TW + 3;

   logic adv;
   logic [N:0] vld;
   sfr_pkg::rot_type th [N+1];
   sfr_pkg::rot_type ph [N+1];
   sfr_pkg::side_type sd [N+1];
   logic rsp_valid_ff;

   // The whole pipe moves unless a result is held in the output register.
   assign adv = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   function automatic sfr_pkg::rot_type seed(input logic [15:0] ang);
      sfr_pkg::rot_type r;
      logic [31:0] a, s;
      a = 32'(ang[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
      s = a + 32'h2000_0000;
      r.q = s[31:30];
      r.z = $signed({4'b0, s[29:0]}) - 34'sh2000_0000;
      r.x = sfr_pkg::CORDIC_GAIN;
      r.y = '0;
      return r;
   endfunction

   assign vld[0] = req_valid;
   assign th[0] = seed(req_polar_angle);
   assign ph[0] = seed(req_azimuth_angle);
   assign sd[0] = '{req_opcode, req_vec_x, req_vec_y, req_vec_z};

   for (genvar i = 0; i < N; i++) begin : g_cell
      sfr_cordic_cell #(.STEP(i)) u_cell (
         .clock(clock), .reset(reset), .adv(adv),
         .vld_in(vld[i]), .th_in(th[i]), .ph_in(ph[i]), .sd_in(sd[i]),
         .vld_out(vld[i+1]), .th_out(th[i+1]), .ph_out(ph[i+1]),
         .sd_out(sd[i+1])
      );
   end

   // Quadrant turn, round and clamp of one CORDIC result.
   function automatic logic signed [TW-1:0] trig(input logic signed [33:0] v);
      logic signed [34:0] r;
      logic signed [34:0] lim;
      r = (35'(v) + (35'sd1 <<< (RS - 1))) >>> RS;
      lim = 35'sd1 <<< TRIG_FRAC_BITS;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return TW'(r);
   endfunction

   function automatic logic signed [2*TW-1:0] sc(input sfr_pkg::rot_type a);
      logic signed [33:0] c, s;
      case (a.q)
         2'd0: begin c = a.x;  s = a.y;  end
         2'd1: begin c = -a.y; s = a.x;  end
         2'd2: begin c = -a.x; s = -a.y; end
         default: begin c = a.y; s = -a.x; end
      endcase
      return {trig(s), trig(c)};
   endfunction

   function automatic logic signed [TW-1:0] tm(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] r;
      r = (p + (PW'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
      return TW'(r);
   endfunction

   // Stage A: sine and cosine.
   logic [4:0] bv_ff;
   logic signed [TW-1:0] st_ff, ct_ff, sp_ff, cp_ff;
   sfr_pkg::side_type sa_ff, sb_ff, sc_ff;
   // Stage B: trig products.
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [TW-1:0] st_b, ct_b, sp_b, cp_b;
   // Stage C: matrix entries.
   logic signed [TW-1:0] m_ff [9];
   // Stage D: element products.
   logic signed [32+TW-1:0] e_ff [9];
   // Stage E: row sums.
   logic signed [SW-1:0] r_ff [3];

   logic signed [TW-1:0] m_in [9];
   always_comb begin
      m_in[0] = -tm(p0_ff); m_in[1] = -tm(p1_ff); m_in[2] = st_b;
      m_in[3] = sp_b;       m_in[4] = -cp_b;      m_in[5] = '0;
      m_in[6] = tm(p2_ff);  m_in[7] = tm(p3_ff);  m_in[8] = ct_b;
      if (sb_ff.opcode) begin
         m_in[1] = sp_b;       m_in[3] = -tm(p1_ff);
         m_in[2] = tm(p2_ff);  m_in[6] = st_b;
         m_in[5] = tm(p3_ff);  m_in[7] = '0;
      end
   end

   function automatic logic signed [31:0] vsel(input sfr_pkg::side_type s,
                                              input int k);
      return (k == 0) ? s.vx : (k == 1) ? s.vy : s.vz;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) bv_ff <= '0;
      else if (adv) bv_ff <= {bv_ff[3:0], vld[N]};
      if (adv) begin
         {st_ff, ct_ff} <= sc(th[N]);
         {sp_ff, cp_ff} <= sc(ph[N]);
         sa_ff <= sd[N];
         p0_ff <= ct_ff * cp_ff;
         p1_ff <= ct_ff * sp_ff;
         p2_ff <= st_ff * cp_ff;
         p3_ff <= st_ff * sp_ff;
         st_b <= st_ff; ct_b <= ct_ff; sp_b <= sp_ff; cp_b <= cp_ff;
         sb_ff <= sa_ff;
         for (int k = 0; k < 9; k++) m_ff[k] <= m_in[k];
         sc_ff <= sb_ff;
         for (int k = 0; k < 9; k++)
            e_ff[k] <= m_ff[k] * vsel(sc_ff, k % 3);
         for (int k = 0; k < 3; k++)
            r_ff[k] <= SW'(e_ff[3*k]) + SW'(e_ff[3*k+1]) + SW'(e_ff[3*k+2]);
      end
   end

   // Final rounding and saturation into the output register.
   logic [31:0] o_in [3];
   logic [2:0] sat_in;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [SW-1:0] r;
         r = (r_ff[k] + (SW'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
         sat_in[k] = 1'b0;
         o_in[k] = r[31:0];
         if (r > SW'(32'sh7fff_ffff)) begin o_in[k] = 32'h7fff_ffff; sat_in[k] = 1'b1; end
         if (r < -(SW'(1) <<< 31)) begin o_in[k] = 32'h8000_0000; sat_in[k] = 1'b1; end
      end
   end

   logic [31:0] ox_ff, oy_ff, oz_ff;
   logic os_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= bv_ff[4];
      if (adv) begin
         ox_ff <= o_in[0]; oy_ff <= o_in[1]; oz_ff <= o_in[2];
         os_ff <= |sat_in;
      end
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_rot_x = ox_ff;
   assign rsp_rot_y = oy_ff;
   assign rsp_rot_z = oz_ff;
   assign rsp_saturated = os_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rot_x) && $stable(rsp_saturated))
      else $error("held result changed");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall not tied to output hold");
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(bv_ff))
      else $error("pipeline moved while stalled");
endmodule
`default_nettype wire

// File: rtl/sfr_cordic_cell.sv
// One CORDIC rotation cell: a single micro-rotation for theta and phi
// plus a register stage. Depends on sfr_pkg.
`default_nettype none
module sfr_cordic_cell #(
   parameter int STEP = 0
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               adv,
   input  wire               vld_in,
   input  sfr_pkg::rot_type  th_in,
   input  sfr_pkg::rot_type  ph_in,
   input  sfr_pkg::side_type sd_in,
   output logic              vld_out,
   output sfr_pkg::rot_type  th_out,
   output sfr_pkg::rot_type  ph_out,
   output sfr_pkg::side_type sd_out
);
   localparam logic signed [33:0] ATAN = sfr_pkg::atan_step(5'(STEP));
   sfr_pkg::rot_type th_in_c, ph_in_c, th_ff, ph_ff;
   sfr_pkg::side_type sd_ff;
   logic vld_ff;

   function automatic sfr_pkg::rot_type turn(input sfr_pkg::rot_type a);
      sfr_pkg::rot_type r;
      r = a;
      if (!a.z[33]) begin
         r.x = a.x - (a.y >>> STEP);
         r.y = a.y + (a.x >>> STEP);
         r.z = a.z - ATAN;
      end else begin
         r.x = a.x + (a.y >>> STEP);
         r.y = a.y - (a.x >>> STEP);
         r.z = a.z + ATAN;
      end
      return r;
   endfunction

   assign th_in_c = turn(th_in);
   assign ph_in_c = turn(ph_in);

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (adv) vld_ff <= vld_in;
      if (adv) begin
         th_ff <= th_in_c;
         ph_ff <= ph_in_c;
         sd_ff <= sd_in;
      end
   end
   assign vld_out = vld_ff;
   assign th_out = th_ff;
   assign ph_out = ph_ff;
   assign sd_out = sd_ff;
endmodule
`default_nettype wire
